/* hw/rtl/rm2ea_pkg.sv */
// ----------------------------------------------------------------------------
// rm2ea_pkg
// Shared widths, constants and the arctangent table for the rotation matrix
// to Euler angle pipeline.
// ----------------------------------------------------------------------------
package rm2ea_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 30;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    // datapath widths
    localparam int IN_W   = 18;
    localparam int GUARD  = 12;
    localparam int XW     = 34;
    localparam int ZW     = 34;
    localparam int ANG_W  = 19;
    localparam int RND_W  = ZW - 14;

    // square root: remainder/root width and number of digit steps
    localparam int SQRT_STEPS = 31;
    localparam int SQ_W       = 2 * SQRT_STEPS;
    localparam int MAG_W      = 30;

    localparam logic signed [ZW-1:0]    HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [RND_W-1:0] FULL_LIMIT  = 20'sd205887;
    localparam logic signed [RND_W-1:0] HALF_LIMIT  = 20'sd102944;

    typedef struct packed {
        logic signed [IN_W-1:0] r00;
        logic signed [IN_W-1:0] r01;
        logic signed [IN_W-1:0] r02;
        logic signed [IN_W-1:0] r11;
        logic signed [IN_W-1:0] r21;
    } t_mat;

    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/rm2ea_cordic.sv */
// ----------------------------------------------------------------------------
// rm2ea_cordic
// Pipelined vectoring CORDIC: atan2(y, x) with quadrant pre-rotation, one
// micro-rotation per stage, then rounding to Q2.16 and saturation.
// ----------------------------------------------------------------------------
module rm2ea_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_half,
    input  logic signed [rm2ea_pkg::XW-1:0]     i_x,
    input  logic signed [rm2ea_pkg::XW-1:0]     i_y,
    output logic                                o_valid,
    output logic signed [rm2ea_pkg::ANG_W-1:0]  o_angle
);
    import rm2ea_pkg::*;

    logic signed [XW-1:0] r_x    [0:CORDIC_N];
    logic signed [XW-1:0] r_y    [0:CORDIC_N];
    logic signed [ZW-1:0] r_z    [0:CORDIC_N];
    logic                 r_zero [0:CORDIC_N];
    logic                 r_half [0:CORDIC_N];
    logic                 r_v    [0:CORDIC_N];

    logic signed [XW-1:0]    n_x;
    logic signed [XW-1:0]    n_y;
    logic signed [ZW-1:0]    n_z;
    logic signed [ZW-1:0]    n_zr;
    logic signed [RND_W-1:0] n_rnd;
    logic signed [RND_W-1:0] n_lim;
    logic signed [RND_W-1:0] n_sat;

    // quarter-turn pre-rotation for a negative x
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = '0;
        if (i_x[XW-1]) begin
            if (!i_y[XW-1]) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = HALF_PI_Q30;
            end else begin
                n_x = -i_y;
                n_y = i_x;
                n_z = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]    <= i_valid;
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_half[0] <= i_half;
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1]    <= r_v[i];
                r_zero[i+1] <= r_zero[i];
                r_half[i+1] <= r_half[i];
                if (!r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end
            end
        end
    end

    // round to Q.16 and clamp
    always_comb begin
        n_zr  = r_z[CORDIC_N] + ZW'(1 << 13);
        n_rnd = RND_W'(n_zr >>> 14);
        n_lim = r_half[CORDIC_N] ? HALF_LIMIT : FULL_LIMIT;
        if (r_zero[CORDIC_N]) begin
            n_sat = '0;
        end else if (n_rnd > n_lim) begin
            n_sat = n_lim;
        end else if (n_rnd < -n_lim) begin
            n_sat = -n_lim;
        end else begin
            n_sat = n_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[CORDIC_N];
            o_angle <= n_sat[ANG_W-1:0];
        end
    end

endmodule

/* hw/rtl/rotation_matrix_to_euler_angles_core.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core: matrix entries to roll, yaw, pitch
// Data passes the squaring and sum-of-squares registers, then the
// one-digit-per-stage square root, then the CORDIC stages.
// Throughput one transaction per cycle; the whole pipeline halts on output stall.
// Synchronous active-low reset clears every valid bit; data registers keep junk.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // r00, r01, r02, r11, r21 (18 b each), zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // roll_angle (19 b), yaw_angle (18 b), pitch_angle (19 b)
);
    import rm2ea_pkg::*;

    logic en;

    t_mat                   n_mat;
    t_mat                   r_mat_a;
    logic [2*IN_W-1:0]      r_sq00;
    logic [2*IN_W-1:0]      r_sq02;
    logic                   r_vld_a;
    t_mat                   r_mat_b;
    logic [SQ_W-1:0]        r_rem_b;
    logic                   r_vld_b;

    t_mat                   r_mat [0:SQRT_STEPS-1];
    logic [SQ_W-1:0]        r_rem [0:SQRT_STEPS-1];
    logic [SQ_W-1:0]        r_res [0:SQRT_STEPS-1];
    logic                   r_vld [0:SQRT_STEPS-1];

    logic signed [2*IN_W-1:0] n_p00;
    logic signed [2*IN_W-1:0] n_p02;

    t_mat                   m_fin;
    logic signed [XW-1:0]   x_roll;
    logic signed [XW-1:0]   y_roll;
    logic signed [XW-1:0]   x_pitch;
    logic signed [XW-1:0]   y_pitch;
    logic signed [XW-1:0]   x_yaw;
    logic signed [XW-1:0]   y_yaw;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] pitch;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign n_mat.r00 = s_axis_tdata[17:0];
    assign n_mat.r01 = s_axis_tdata[35:18];
    assign n_mat.r02 = s_axis_tdata[53:36];
    assign n_mat.r11 = s_axis_tdata[71:54];
    assign n_mat.r21 = s_axis_tdata[89:72];

    assign n_p00 = n_mat.r00 * n_mat.r00;
    assign n_p02 = n_mat.r02 * n_mat.r02;

    // squares, then the Q.56 sum of squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (en) begin
            r_vld_a <= s_axis_tvalid;
            r_mat_a <= n_mat;
            r_sq00  <= n_p00;
            r_sq02  <= n_p02;
            r_vld_b <= r_vld_a;
            r_mat_b <= r_mat_a;
            r_rem_b <= SQ_W'({({1'b0, r_sq00} + {1'b0, r_sq02}), {(2*GUARD){1'b0}}});
        end
    end

    // digit-by-digit square root, one root bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] res_in;
        t_mat            mat_in;
        logic            vld_in;
        logic [SQ_W-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in = r_rem_b;
            assign res_in = '0;
            assign mat_in = r_mat_b;
            assign vld_in = r_vld_b;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign res_in = r_res[k-1];
            assign mat_in = r_mat[k-1];
            assign vld_in = r_vld[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= vld_in;
                r_mat[k] <= mat_in;
                if (rem_in >= trial) begin
                    r_rem[k] <= rem_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_rem[k] <= rem_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign m_fin   = r_mat[SQRT_STEPS-1];
    assign x_roll  = {{(XW-IN_W-GUARD){m_fin.r11[IN_W-1]}}, m_fin.r11, {GUARD{1'b0}}};
    assign y_roll  = {{(XW-IN_W-GUARD){m_fin.r21[IN_W-1]}}, m_fin.r21, {GUARD{1'b0}}};
    assign x_pitch = {{(XW-IN_W-GUARD){m_fin.r00[IN_W-1]}}, m_fin.r00, {GUARD{1'b0}}};
    assign y_pitch = {{(XW-IN_W-GUARD){m_fin.r02[IN_W-1]}}, m_fin.r02, {GUARD{1'b0}}};
    assign x_yaw   = XW'(r_res[SQRT_STEPS-1][MAG_W-1:0]);
    assign y_yaw   = -{{(XW-IN_W-GUARD){m_fin.r01[IN_W-1]}}, m_fin.r01, {GUARD{1'b0}}};

    rm2ea_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[SQRT_STEPS-1]),
        .i_half  (1'b0),
        .i_x     (x_roll),
        .i_y     (y_roll),
        .o_valid (),
        .o_angle (roll)
    );

    rm2ea_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[SQRT_STEPS-1]),
        .i_half  (1'b1),
        .i_x     (x_yaw),
        .i_y     (y_yaw),
        .o_valid (m_axis_tvalid),
        .o_angle (yaw)
    );

    rm2ea_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[SQRT_STEPS-1]),
        .i_half  (1'b0),
        .i_x     (x_pitch),
        .i_y     (y_pitch),
        .o_valid (),
        .o_angle (pitch)
    );

    assign m_axis_tdata = {pitch, yaw[ANG_W-2:0], roll};

`ifndef ASSERT_OFF
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld_a)
        else $error("accepted transaction did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld_b) && $stable(r_vld[SQRT_STEPS-1]))
        else $error("pipeline moved during output stall");

    a_yaw_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (yaw <= 19'sd102944) && (yaw >= -19'sd102944))
        else $error("yaw outside half-pi range");

    a_roll_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (roll <= 19'sd205887) && (roll >= -19'sd205887))
        else $error("roll outside pi range");
`endif

endmodule

/* tb/sv/tb_rotation_matrix_to_euler_angles_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_euler_angles_core
// Drives matrix entries into the core and checks roll, yaw and pitch against
// a bit-accurate CORDIC and integer square root model held in a scoreboard.
// Random idling on both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_euler_angles_core;
    import rm2ea_pkg::*;

    typedef struct packed {
        logic signed [18:0] pitch;
        logic signed [17:0] yaw;
        logic signed [18:0] roll;
    } t_angles;

    int n_errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        n_errors++;
    endtask

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint angle_table(input int i);
        longint tab [30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
            32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    function automatic longint vector_angle(input longint y, input longint x,
                                            input longint lim);
        longint z, r, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 1686629713;
            end else begin
                x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + angle_table(i);
            end else begin
                x = x - ys; y = y + xs; z = z - angle_table(i);
            end
        end
        r = shr_floor(z + (64'sd1 << 13), 14);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles predict_angles(input t_mat m);
        longint a00, a01, a02, a11, a21, mag;
        t_angles a;
        a00 = longint'(m.r00) * 4096;
        a01 = longint'(m.r01) * 4096;
        a02 = longint'(m.r02) * 4096;
        a11 = longint'(m.r11) * 4096;
        a21 = longint'(m.r21) * 4096;
        mag = int_sqrt(a00 * a00 + a02 * a02);
        a.roll  = 19'(vector_angle(a21, a11, 205887));
        a.yaw   = 18'(vector_angle(-a01, mag, 102944));
        a.pitch = 19'(vector_angle(a02, a00, 205887));
        return a;
    endfunction

    class angle_scoreboard;
        t_angles pending[$];

        function void note_matrix(t_mat m);
            pending.push_back(predict_angles(m));
        endfunction

        task check_angles(t_angles got);
            t_angles want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected transaction", got, 0);
                return;
            end
            want = pending.pop_front();
            if (got.roll != want.roll) report_mismatch("roll", got.roll, want.roll);
            if (got.yaw != want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
            if (got.pitch != want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;  // r00, r01, r02, r11, r21 (18 b each), zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;       // roll_angle, yaw_angle, pitch_angle

    angle_scoreboard sb = new();
    bit quiet_phase = 0;
    bit hold_output = 0;

    rotation_matrix_to_euler_angles_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [95:0] pack_matrix(input t_mat m);
        return {6'd0, m.r21, m.r11, m.r02, m.r01, m.r00};
    endfunction

    function automatic logic signed [17:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 18'sh10000;
            1: return -18'sh10000;
            2: return '0;
            3: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic send_matrix(input t_mat m);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= pack_matrix(m);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_matrix(m);
    endtask

    task automatic send_entries(input int a, b, c, d, e);
        t_mat m;
        m.r00 = 18'(a); m.r01 = 18'(b); m.r02 = 18'(c); m.r11 = 18'(d); m.r21 = 18'(e);
        send_matrix(m);
    endtask

    // Output side: random stall bursts, plus a long hold on request.
    always @(posedge i_clk) begin
        t_angles got;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            sb.check_angles(got);
        end
    end

    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                // hold off long enough to fill the pipeline and stall the input
                m_axis_tready <= 0;
                repeat (200) @(posedge i_clk);
                hold_output = 0;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 14);
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_mat m;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // extremes, zero pairs, negative x on both sides of y = 0
        send_entries(0, 0, 0, 0, 0);
        send_entries(65536, 0, 0, 65536, 0);
        send_entries(-65536, 0, 0, -65536, 0);
        send_entries(-65536, 65536, 0, -65536, -1);
        send_entries(0, -65536, 65536, 0, 65536);
        send_entries(0, 65536, -65536, 0, -65536);
        send_entries(-65536, -65536, -65536, -65536, -65536);
        send_entries(65536, 65536, 65536, 65536, 65536);
        send_entries(-131072, 131071, -131072, 131071, -131072);
        send_entries(131071, -131072, 131071, -131072, 131071);
        send_entries(-1, 1, 1, -1, 1);
        send_entries(-46341, 46341, 46341, -46341, 46341);
        send_entries(0, 0, 0, 0, 1);
        send_entries(-1, 0, -1, -1, -1);
        send_entries(0, 1, 0, 1, 0);
        for (int i = 0; i < 1000; i++) begin
            if (i == 300) hold_output = 1;
            if (i == 600) begin
                s_axis_tvalid <= 0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if (i == 900) quiet_phase = 1;
            m.r00 = rand_entry(); m.r01 = rand_entry(); m.r02 = rand_entry();
            m.r11 = rand_entry(); m.r21 = rand_entry();
            send_matrix(m);
        end
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("tb_rotation_matrix_to_euler_angles_core: PASS");
        else
            $display("tb_rotation_matrix_to_euler_angles_core: FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_rotation_matrix_to_euler_angles_core: FAIL");
        $finish;
    end
endmodule
